// ===== sv/msor_pkg.sv =====
// msor_pkg: shared constants, codes and types of the matrix scan order reader.
// No dependencies; every other file of the block refers to it by scoped names.
package msor_pkg;

  localparam int unsigned MAX_DIM    = 8;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned DIM_W      = 4;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned DEPTH      = MAX_DIM * MAX_DIM;
  localparam int unsigned TOTAL_W    = 7;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [1:0] ORD_ROW    = 2'd0;
  localparam logic [1:0] ORD_SNAKE  = 2'd1;
  localparam logic [1:0] ORD_SPIRAL = 2'd2;
  localparam logic [1:0] ORD_NONE   = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  typedef struct packed {
    logic                         is_scan;
    logic [1:0]                   order;
    logic signed [DATA_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== sv/msor_if.sv =====
// msor_if: valid/ready channel interfaces for requests, results and register writes.
// Depends on msor_pkg for field widths.
interface msor_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic signed [msor_pkg::DATA_WIDTH-1:0] element_value;
  logic [1:0]                            scan_order;
  modport source (output valid, req_type, element_value, scan_order, input ready);
  modport sink (input valid, req_type, element_value, scan_order, output ready);
endinterface

interface msor_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [msor_pkg::DATA_WIDTH-1:0] out_value;
  logic [msor_pkg::IDX_W-1:0]            row_index;
  logic [msor_pkg::IDX_W-1:0]            col_index;
  logic                                  last_of_scan;
  modport source (output valid, out_value, row_index, col_index, last_of_scan, input ready);
  modport sink (input valid, out_value, row_index, col_index, last_of_scan, output ready);
endinterface

interface msor_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [msor_pkg::CFG_IDX_W-1:0]    index;
  logic [msor_pkg::DIM_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/msor_front.sv =====
// msor_front: accepts request transactions and turns them into back-end commands.
// Depends on msor_pkg and msor_if; scans of an unknown order are consumed and dropped.
module msor_front (
  msor_req_if.sink          req,
  output msor_pkg::cmd_t    cmd_o,
  output logic              push_valid_o,
  input  logic              push_ready_i
);

  logic drop;

  assign drop         = (req.req_type == msor_pkg::REQ_SCAN) &&
                        (req.scan_order == msor_pkg::ORD_NONE);
  assign req.ready    = push_ready_i;
  assign push_valid_o = req.valid && !drop;

  assign cmd_o.is_scan = (req.req_type == msor_pkg::REQ_SCAN);
  assign cmd_o.order   = req.scan_order;
  assign cmd_o.value   = req.element_value;

endmodule

// ===== sv/msor_fifo.sv =====
// msor_fifo: two-entry command queue between front and back.
// Depends on msor_pkg for the command type.
module msor_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msor_pkg::cmd_t   push_cmd_i,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  output msor_pkg::cmd_t   pop_cmd_o,
  output msor_pkg::hs_t    pop_hs_o,
  input  logic             pop_ready_i
);

  msor_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign push_ready_o   = (cnt_q != 2'd2);
  assign pop_hs_o.valid = (cnt_q != 2'd0);
  assign pop_hs_o.ready = pop_ready_i;
  assign pop_cmd_o      = slot_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_hs_o.valid && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/msor_back.sv =====
// msor_back: matrix store, load pointer and scan sequencer with the result register.
// Depends on msor_pkg, msor_if; takes commands from msor_fifo.
module msor_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [msor_pkg::DIM_W-1:0]   rows_i,
  input  logic [msor_pkg::DIM_W-1:0]   cols_i,
  input  msor_pkg::cmd_t               cmd_i,
  input  msor_pkg::hs_t                cmd_hs_i,
  output logic                         cmd_ready_o,
  msor_res_if.source                   res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  logic signed [msor_pkg::DATA_WIDTH-1:0] mem_q [msor_pkg::DEPTH];

  logic                              st_q, st_d;
  logic [1:0]                        order_q, order_d;
  logic [1:0]                        dir_q, dir_d;
  logic [msor_pkg::IDX_W-1:0]        r_q, r_d, c_q, c_d;
  logic [msor_pkg::IDX_W-1:0]        top_q, top_d, bot_q, bot_d;
  logic [msor_pkg::IDX_W-1:0]        left_q, left_d, right_q, right_d;
  logic [msor_pkg::ADDR_W-1:0]       cnt_q, cnt_d;
  logic [msor_pkg::ADDR_W-1:0]       pos_q, pos_d;

  logic                              out_valid_q, out_valid_d;
  logic signed [msor_pkg::DATA_WIDTH-1:0] out_value_q;
  logic [msor_pkg::IDX_W-1:0]        out_row_q, out_col_q;
  logic                              out_last_q;

  logic [msor_pkg::TOTAL_W-1:0]      total;
  logic [msor_pkg::ADDR_W-1:0]       total_m1;
  logic [msor_pkg::IDX_W-1:0]        rows_m1, cols_m1;
  logic [msor_pkg::TOTAL_W-1:0]      rd_addr_full;
  logic [msor_pkg::ADDR_W-1:0]       rd_addr;
  logic [msor_pkg::ADDR_W-1:0]       wr_pos;
  logic [msor_pkg::TOTAL_W-1:0]      wr_next;
  logic                              take_cmd, do_load, slot_free, emit, is_last;

  assign total    = msor_pkg::TOTAL_W'(rows_i) * msor_pkg::TOTAL_W'(cols_i);
  assign total_m1 = msor_pkg::ADDR_W'(total - msor_pkg::TOTAL_W'(1));
  assign rows_m1  = msor_pkg::IDX_W'(rows_i - msor_pkg::DIM_W'(1));
  assign cols_m1  = msor_pkg::IDX_W'(cols_i - msor_pkg::DIM_W'(1));

  assign cmd_ready_o = (st_q == ST_IDLE);
  assign take_cmd    = cmd_hs_i.valid && cmd_hs_i.ready;
  assign do_load     = take_cmd && !cmd_i.is_scan;

  assign slot_free = !out_valid_q || res.ready;
  assign emit      = (st_q == ST_SCAN) && slot_free;
  assign is_last   = (cnt_q == total_m1);

  assign rd_addr_full = msor_pkg::TOTAL_W'(r_q) * msor_pkg::TOTAL_W'(cols_i) +
                        msor_pkg::TOTAL_W'(c_q);
  assign rd_addr      = rd_addr_full[msor_pkg::ADDR_W-1:0];

  // load pointer restarts if a shape change left it outside the matrix
  assign wr_pos  = (msor_pkg::TOTAL_W'(pos_q) >= total) ? '0 : pos_q;
  assign wr_next = msor_pkg::TOTAL_W'(wr_pos) + msor_pkg::TOTAL_W'(1);

  always_comb begin
    pos_d = pos_q;
    if (do_load) begin
      pos_d = (wr_next >= total) ? '0 : wr_next[msor_pkg::ADDR_W-1:0];
    end
  end

  always_comb begin
    st_d    = st_q;
    order_d = order_q;
    dir_d   = dir_q;
    r_d     = r_q;
    c_d     = c_q;
    top_d   = top_q;
    bot_d   = bot_q;
    left_d  = left_q;
    right_d = right_q;
    cnt_d   = cnt_q;
    if (take_cmd && cmd_i.is_scan) begin
      st_d    = ST_SCAN;
      order_d = cmd_i.order;
      dir_d   = DIR_RIGHT;
      r_d     = '0;
      c_d     = '0;
      top_d   = '0;
      bot_d   = rows_m1;
      left_d  = '0;
      right_d = cols_m1;
      cnt_d   = '0;
    end else if (emit) begin
      cnt_d = cnt_q + msor_pkg::ADDR_W'(1);
      if (is_last) begin
        st_d = ST_IDLE;
      end
      case (order_q)
        msor_pkg::ORD_ROW: begin
          if (c_q == cols_m1) begin
            c_d = '0;
            r_d = r_q + msor_pkg::IDX_W'(1);
          end else begin
            c_d = c_q + msor_pkg::IDX_W'(1);
          end
        end
        msor_pkg::ORD_SNAKE: begin
          if (!c_q[0]) begin
            if (r_q == rows_m1) c_d = c_q + msor_pkg::IDX_W'(1);
            else r_d = r_q + msor_pkg::IDX_W'(1);
          end else begin
            if (r_q == '0) c_d = c_q + msor_pkg::IDX_W'(1);
            else r_d = r_q - msor_pkg::IDX_W'(1);
          end
        end
        default: begin
          case (dir_q)
            DIR_RIGHT: begin
              if (c_q != right_q) begin
                c_d = c_q + msor_pkg::IDX_W'(1);
              end else begin
                top_d = top_q + msor_pkg::IDX_W'(1);
                r_d   = r_q + msor_pkg::IDX_W'(1);
                dir_d = DIR_DOWN;
              end
            end
            DIR_DOWN: begin
              if (r_q != bot_q) begin
                r_d = r_q + msor_pkg::IDX_W'(1);
              end else begin
                right_d = right_q - msor_pkg::IDX_W'(1);
                c_d     = c_q - msor_pkg::IDX_W'(1);
                dir_d   = DIR_LEFT;
              end
            end
            DIR_LEFT: begin
              if (c_q != left_q) begin
                c_d = c_q - msor_pkg::IDX_W'(1);
              end else begin
                bot_d = bot_q - msor_pkg::IDX_W'(1);
                r_d   = r_q - msor_pkg::IDX_W'(1);
                dir_d = DIR_UP;
              end
            end
            default: begin
              if (r_q != top_q) begin
                r_d = r_q - msor_pkg::IDX_W'(1);
              end else begin
                left_d = left_q + msor_pkg::IDX_W'(1);
                c_d    = c_q + msor_pkg::IDX_W'(1);
                dir_d  = DIR_RIGHT;
              end
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    order_q <= order_d;
    dir_q   <= dir_d;
    r_q     <= r_d;
    c_q     <= c_d;
    top_q   <= top_d;
    bot_q   <= bot_d;
    left_q  <= left_d;
    right_q <= right_d;
    cnt_q   <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem_q[wr_pos] <= cmd_i.value;
    end
  end

  // registered memory read doubles as the result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= mem_q[rd_addr];
      out_row_q   <= r_q;
      out_col_q   <= c_q;
      out_last_q  <= is_last;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.out_value    = out_value_q;
  assign res.row_index    = out_row_q;
  assign res.col_index    = out_col_q;
  assign res.last_of_scan = out_last_q;

endmodule

// ===== sv/matrix_scan_order_reader.sv =====
// matrix_scan_order_reader: top level; holds the shape registers and joins front, queue, back.
// Depends on msor_pkg, msor_if, msor_front, msor_fifo, msor_back.
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   req_type, element_value, scan_order
//   res_o    out  valid/ready   out_value, row_index, col_index, last_of_scan
//   cfg_i    in   valid/ready   index (0 rows, 1 cols), data
//
// Loads are written in the back end while it is idle; the front keeps accepting
// while the two-entry queue has room. A scan occupies the back end until its last
// result, one result a cycle while results are taken, paced by the single memory read port.
// Reset clears the load pointer, queue and sequencer; the store holds garbage.
// A stalled result holds the sequencer; requests then queue up to two deep.
module matrix_scan_order_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  msor_req_if.sink    req_i,
  msor_res_if.source  res_o,
  msor_cfg_if.sink    cfg_i
);

  logic [msor_pkg::DIM_W-1:0] rows_q, cols_q;
  logic [msor_pkg::DIM_W-1:0] rows_eff, cols_eff;

  msor_pkg::cmd_t push_cmd, pop_cmd;
  logic           push_valid, push_ready, pop_ready;
  msor_pkg::hs_t  pop_hs;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= msor_pkg::DIM_W'(msor_pkg::MAX_DIM);
      cols_q <= msor_pkg::DIM_W'(msor_pkg::MAX_DIM);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        msor_pkg::REG_ROWS: rows_q <= cfg_i.data;
        msor_pkg::REG_COLS: cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = rows_q;
    cols_eff = cols_q;
    if (rows_q == '0) rows_eff = msor_pkg::DIM_W'(1);
    else if (rows_q > msor_pkg::DIM_W'(msor_pkg::MAX_DIM))
      rows_eff = msor_pkg::DIM_W'(msor_pkg::MAX_DIM);
    if (cols_q == '0) cols_eff = msor_pkg::DIM_W'(1);
    else if (cols_q > msor_pkg::DIM_W'(msor_pkg::MAX_DIM))
      cols_eff = msor_pkg::DIM_W'(msor_pkg::MAX_DIM);
  end

  msor_front u_front (
    .req          (req_i),
    .cmd_o        (push_cmd),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  msor_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (push_cmd),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_cmd_o    (pop_cmd),
    .pop_hs_o     (pop_hs),
    .pop_ready_i  (pop_ready)
  );

  msor_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rows_i      (rows_eff),
    .cols_i      (cols_eff),
    .cmd_i       (pop_cmd),
    .cmd_hs_i    (pop_hs),
    .cmd_ready_o (pop_ready),
    .res         (res_o)
  );

endmodule
